// File: hw/rtl/frame_deframer_with_sum_check_macros.svh
// Assertion macros shared by the frame deframer RTL files.
`ifndef FRAME_DEFRAMER_WITH_SUM_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_WITH_SUM_CHECK_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is high.
`define FDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an expression never holds on a rising edge of clk_i.
`define FDSC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hw/rtl/fdsc_pkg.sv
// Types and constants of the frame deframer with sum check.
`default_nettype none

package fdsc_pkg;

  localparam int unsigned CountW   = 17;
  localparam int unsigned MinFrame = 7;
  localparam int unsigned HdrBytes = 5;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Register index of the expected magic value.
  localparam logic RegHeaderMagic = 1'b0;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [2:0] {
    VerdictOk          = 3'd0,
    VerdictTooShort    = 3'd1,
    VerdictBadMagic    = 3'd2,
    VerdictLenMismatch = 3'd3,
    VerdictBadSum      = 3'd4
  } verdict_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
    verdict_e    verdict;
    logic        last;
  } result_t;

  // Up to two results are written into the result queue per accepted byte.
  typedef struct packed {
    logic    first;
    logic    second;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/fdsc_res_queue.sv
// Four-entry result queue, written with up to two results and read with one per cycle while out_ready_i is high.
`default_nettype none

module fdsc_res_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fdsc_pkg::push_t  push_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fdsc_pkg::result_t     out_o
);
  import fdsc_pkg::*;
  `include "frame_deframer_with_sum_check_macros.svh"

  result_t              entries_q [QDepth];
  logic [QPtrW-1:0]     wptr_q, wptr_d;
  logic [QPtrW-1:0]     rptr_q, rptr_d;
  logic [QPtrW:0]       count_q, count_d;
  logic                 pop;
  logic [QPtrW:0]       num_push;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_o       = entries_q[rptr_q];
  // Room for two more results is kept so that any byte can be taken.
  assign ready_o     = (count_q <= (QPtrW+1)'(QDepth - 2));

  always_comb begin
    num_push = (QPtrW+1)'(push_i.first) + (QPtrW+1)'(push_i.second);
    wptr_d   = wptr_q + num_push[QPtrW-1:0];
    rptr_d   = pop ? rptr_q + QPtrW'(1) : rptr_q;
    count_d  = count_q + num_push - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      entries_q[wptr_q] <= push_i.res0;
    end
    if (push_i.second) begin
      entries_q[wptr_q + QPtrW'(1)] <= push_i.res1;
    end
  end

  `FDSC_ASSERT_NEVER(a_count_bound, count_q > (QPtrW+1)'(QDepth), "result queue overflow")
  `FDSC_ASSERT(a_second_needs_first, push_i.second |-> push_i.first, "second push without first")
  `FDSC_ASSERT_NEVER(a_push_when_full, push_i.first && !ready_o, "push while queue has no room")

endmodule

`default_nettype wire

// File: hw/rtl/frame_deframer_with_sum_check.sv
// Top level of the frame deframer with 16-bit additive sum check.
`default_nettype none

// Parses a length-prefixed frame (magic, length, type, payload, checksum, all
// big-endian) from a byte stream whose final byte carries tlast. Each accepted
// byte updates the frame state, and its results are written into a four-entry
// result queue in the cycle of acceptance. Payload bytes come out once the
// magic has matched, and the final byte brings one verdict result (tuser
// high). The output side drains one result per clock while m_axis_tready is
// high, so a stream then sustains one byte per clock; a final byte that is
// also a payload byte makes two results. s_axis_tready is low while the queue
// holds more than two results.
module frame_deframer_with_sum_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Byte input.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_buffer
  // Result output.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] packet_type, [31:16] payload_length,
  // [34:32] verdict, [39:35] zero
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // result_kind
  output logic             m_axis_tlast    // last_of_run
);
  import fdsc_pkg::*;
  `include "frame_deframer_with_sum_check_macros.svh"

  logic [15:0]       header_magic_q;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [15:0]       magic_q, magic_d;
  logic [15:0]       length_q, length_d;
  logic [7:0]        type_q, type_d;
  logic [15:0]       sum_q, sum_d;
  logic [15:0]       check_q, check_d;

  logic              accept;
  logic [7:0]        din;
  logic [CountW-1:0] pay_end;
  logic              past_hdr, in_pay, pay_emit;
  logic [15:0]       expect_sum;
  verdict_e          verdict;
  result_t           pay_res, ver_res, out_res;
  push_t             push;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_magic_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegHeaderMagic)) begin
      header_magic_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == RegHeaderMagic) ? {16'b0, header_magic_q} : 32'b0;

  // Frame state update for the byte at hand.
  assign accept = s_axis_tvalid && s_axis_tready;
  assign din    = s_axis_tdata;

  always_comb begin
    magic_d  = magic_q;
    length_d = length_q;
    type_d   = type_q;
    sum_d    = sum_q;
    check_d  = check_q;

    unique case (byte_count_q)
      CountW'(0): magic_d  = {din, 8'h00};
      CountW'(1): magic_d  = {magic_q[15:8], din};
      CountW'(2): length_d = {din, 8'h00};
      CountW'(3): length_d = {length_q[15:8], din};
      CountW'(4): type_d   = din;
      default: ;
    endcase

    // The length field is complete before the payload starts.
    pay_end  = CountW'(HdrBytes) + {1'b0, length_q};
    past_hdr = (byte_count_q >= CountW'(HdrBytes));
    in_pay   = past_hdr && (byte_count_q < pay_end);

    if (in_pay) begin
      sum_d = sum_q + {8'h00, din};
    end else if (past_hdr && (byte_count_q == pay_end)) begin
      check_d = {din, 8'h00};
    end else if (past_hdr && (byte_count_q == pay_end + CountW'(1))) begin
      check_d = {check_q[15:8], din};
    end

    pay_emit     = in_pay && (magic_d == header_magic_q);
    byte_count_d = (byte_count_q != CountMax) ? byte_count_q + CountW'(1) : byte_count_q;
  end

  always_comb begin
    expect_sum = magic_d + length_d + {8'h00, type_d} + sum_d;
    if (byte_count_d < CountW'(MinFrame)) begin
      verdict = VerdictTooShort;
    end else if (magic_d != header_magic_q) begin
      verdict = VerdictBadMagic;
    end else if (byte_count_d != CountW'(MinFrame) + {1'b0, length_d}) begin
      verdict = VerdictLenMismatch;
    end else if (expect_sum != check_d) begin
      verdict = VerdictBadSum;
    end else begin
      verdict = VerdictOk;
    end
  end

  always_comb begin
    pay_res.kind           = KindPayload;
    pay_res.payload_byte   = din;
    pay_res.packet_type    = type_d;
    pay_res.payload_length = length_d;
    pay_res.verdict        = VerdictOk;
    pay_res.last           = !s_axis_tlast;

    ver_res.kind           = KindVerdict;
    ver_res.payload_byte   = 8'h00;
    ver_res.packet_type    = type_d;
    ver_res.payload_length = length_d;
    ver_res.verdict        = verdict;
    ver_res.last           = 1'b1;

    push.first  = accept && (pay_emit || s_axis_tlast);
    push.second = accept && pay_emit && s_axis_tlast;
    push.res0   = pay_emit ? pay_res : ver_res;
    push.res1   = ver_res;
  end

  // The verdict returns the frame state to its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      magic_q      <= '0;
      length_q     <= '0;
      type_q       <= '0;
      sum_q        <= '0;
      check_q      <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        byte_count_q <= '0;
        magic_q      <= '0;
        length_q     <= '0;
        type_q       <= '0;
        sum_q        <= '0;
        check_q      <= '0;
      end else begin
        byte_count_q <= byte_count_d;
        magic_q      <= magic_d;
        length_q     <= length_d;
        type_q       <= type_d;
        sum_q        <= sum_d;
        check_q      <= check_d;
      end
    end
  end

  fdsc_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.verdict, out_res.payload_length,
                         out_res.packet_type, out_res.payload_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  `FDSC_ASSERT(a_verdict_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "verdict not last")
  `FDSC_ASSERT(a_clear_after_end, (accept && s_axis_tlast) |=> (byte_count_q == '0), "frame state not cleared")
  `FDSC_ASSERT(a_payload_no_verdict, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[34:32] == VerdictOk), "payload result carries a verdict")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the frame deframer with 16-bit additive sum check.
`timescale 1ns / 1ps

module testbench;
  import fdsc_pkg::*;

  localparam logic [2:0] MagicAddr    = 3'(RegHeaderMagic) * 3'd4;
  localparam int         IdlePct      = 18;
  localparam int         RandomItems  = 1550;
  localparam int         StallLimit   = 1000;
  localparam int         SettleCycles = 8;

  // Tracks the frame state of the block and holds the results it must produce.
  class frame_checker;
    logic [15:0] magic_cfg;
    logic [16:0] byte_count;
    logic [15:0] magic_word;
    logic [15:0] length_word;
    logic [7:0]  type_byte;
    logic [15:0] running_sum;
    logic [15:0] received_check;
    result_t     expected_results[$];
    int          errors;

    function new();
      magic_cfg = '0;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count     = '0;
      magic_word     = '0;
      length_word    = '0;
      type_byte      = '0;
      running_sum    = '0;
      received_check = '0;
    endfunction

    function void push_result(logic kind, logic [7:0] pay, verdict_e verd, logic lst);
      result_t r;
      r.kind           = kind;
      r.payload_byte   = pay;
      r.packet_type    = type_byte;
      r.payload_length = length_word;
      r.verdict        = verd;
      r.last           = lst;
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Advances the frame state by one accepted byte and queues what it causes.
    function void take_byte(logic [7:0] b, logic eob);
      int unsigned idx;
      int unsigned pay_end;
      logic [15:0] sum;
      verdict_e    verd;
      idx = byte_count;
      case (idx)
        0: magic_word = {b, 8'h00};
        1: magic_word[7:0] = b;
        2: length_word = {b, 8'h00};
        3: length_word[7:0] = b;
        4: type_byte = b;
        default: ;
      endcase
      pay_end = HdrBytes + length_word;
      if (idx >= HdrBytes && idx < pay_end) begin
        running_sum = running_sum + 16'(b);
        // A payload byte is the last result of its step unless the buffer ends here.
        if (magic_word == magic_cfg) push_result(KindPayload, b, VerdictOk, !eob);
      end else if (idx >= HdrBytes && idx == pay_end) begin
        received_check = {b, 8'h00};
      end else if (idx >= HdrBytes && idx == pay_end + 1) begin
        received_check[7:0] = b;
      end
      if (byte_count != CountMax) byte_count = byte_count + 17'd1;
      if (eob) begin
        sum = magic_word + length_word + 16'(type_byte) + running_sum;
        if (byte_count < MinFrame) verd = VerdictTooShort;
        else if (magic_word != magic_cfg) verd = VerdictBadMagic;
        else if (int'(byte_count) != MinFrame + length_word) verd = VerdictLenMismatch;
        else if (sum != received_check) verd = VerdictBadSum;
        else verd = VerdictOk;
        push_result(KindVerdict, 8'h00, verd, 1'b1);
        clear_frame();
      end
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [39:0] data, logic kind, logic lst);
      result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0b data 0x%0h",
                 $time, kind, data);
        return;
      end
      e = expected_results.pop_front();
      compare_field("result_kind", 16'(e.kind), 16'(kind));
      compare_field("payload_byte", 16'(e.payload_byte), 16'(data[7:0]));
      compare_field("packet_type", 16'(e.packet_type), 16'(data[15:8]));
      compare_field("payload_length", e.payload_length, data[31:16]);
      compare_field("verdict", 16'(e.verdict), 16'(data[34:32]));
      compare_field("tdata padding", 16'h0000, 16'(data[39:35]));
      compare_field("last_of_run", 16'(e.last), 16'(lst));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  frame_checker chk;
  logic [7:0]   frame_bytes[$];
  bit           tx_busy;
  int           tx_idle_pct;
  int           rx_idle_pct;
  int           random_items;
  int           stall_cycles;

  frame_deframer_with_sum_check u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Result checking and the watchdog on forward progress.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) chk.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no request accepted for %0d cycles", $time, StallLimit);
        $display("frame_deframer_with_sum_check verification failed");
        $finish;
      end
    end
  end

  function void add_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  task tx_release();
    if (tx_busy) begin
      s_axis_tvalid <= 1'b0;
      tx_busy = 1'b0;
    end
  endtask

  task send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < tx_idle_pct) begin
      tx_release();
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    tx_busy = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chk.take_byte(b, eob);
  endtask

  task send_bytes(input int first, input int final_idx, input bit mark_end);
    for (int i = first; i <= final_idx; i++)
      send_byte(frame_bytes[i], mark_end && i == final_idx);
  endtask

  // Holds the sender off until every queued result has been drained.
  task wait_drained();
    tx_release();
    do @(posedge clk_i); while (chk.expected_results.size() != 0);
  endtask

  task apb_write(input logic [2:0] addr, input logic [15:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    chk.magic_cfg = value;
  endtask

  // Fills frame_bytes with a well-formed frame carrying random payload.
  task build_frame(input logic [15:0] magic, input int len, input logic [7:0] pkt_type);
    logic [15:0] sum;
    logic [7:0]  b;
    frame_bytes.delete();
    add_byte(magic[15:8]);
    add_byte(magic[7:0]);
    add_byte(8'(len >> 8));
    add_byte(8'(len));
    add_byte(pkt_type);
    sum = magic + 16'(len) + 16'(pkt_type);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      add_byte(b);
      sum = sum + 16'(b);
    end
    add_byte(sum[15:8]);
    add_byte(sum[7:0]);
  endtask

  task random_buffer();
    int          r;
    int          len;
    int          cut;
    logic [15:0] magic;
    r     = $urandom_range(99);
    len   = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
    magic = chk.magic_cfg;
    if (r >= 58 && r < 66) magic = magic ^ 16'($urandom_range(16'hFFFF, 1));
    build_frame(magic, len, 8'($urandom_range(255)));
    if (r < 50) begin
    end else if (r < 58) begin
      cut = frame_bytes.size() - 1 - $urandom_range(1);
      frame_bytes[cut] = frame_bytes[cut] ^ 8'(1 << $urandom_range(7));
    end else if (r < 66) begin
    end else if (r < 74) begin
      if ($urandom_range(1)) begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
      end else begin
        cut = $urandom_range(frame_bytes.size() - 1, HdrBytes);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
    end else if (r < 84) begin
      cut = $urandom_range(MinFrame - 1, 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(24, 1)) add_byte(8'($urandom_range(255)));
    end
    send_bytes(0, frame_bytes.size() - 1, 1'b1);
    random_items += frame_bytes.size();
  endtask

  initial begin
    int          cfg_phase;
    logic [15:0] magic_val;
    chk           = new();
    tx_busy       = 1'b0;
    tx_idle_pct   = IdlePct;
    rx_idle_pct   = IdlePct;
    random_items  = 0;
    cfg_phase     = -1;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Minimal frame with all-zero fields against the reset magic.
    build_frame(16'h0000, 0, 8'h00);
    send_bytes(0, frame_bytes.size() - 1, 1'b1);
    // A single byte that ends its buffer.
    frame_bytes.delete();
    add_byte(8'hFF);
    send_bytes(0, 0, 1'b1);
    // All-ones magic and type with one all-ones payload byte.
    apb_write(MagicAddr, 16'hFFFF);
    build_frame(16'hFFFF, 1, 8'hFF);
    frame_bytes[5] = 8'hFF;
    frame_bytes[6] = 8'h01;
    frame_bytes[7] = 8'hFE;
    send_bytes(0, frame_bytes.size() - 1, 1'b1);
    // A short buffer that ends on a payload byte gives two results in one step.
    build_frame(16'hFFFF, 3, 8'h7E);
    send_bytes(0, 5, 1'b1);
    // The magic register changes while a matched frame is half received.
    build_frame(16'hFFFF, 2, 8'h5A);
    send_bytes(0, 5, 1'b0);
    apb_write(MagicAddr, 16'h1234);
    send_bytes(6, frame_bytes.size() - 1, 1'b1);

    while (random_items < RandomItems) begin
      if (random_items / 260 != cfg_phase) begin
        cfg_phase = random_items / 260;
        case (cfg_phase)
          0: magic_val = 16'h0000;
          2: magic_val = 16'hFFFF;
          5: magic_val = 16'h8001;
          default: magic_val = 16'($urandom_range(16'hFFFF));
        endcase
        apb_write(MagicAddr, magic_val);
      end
      if (random_items >= 700 && random_items < 1000) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IdlePct;
        rx_idle_pct = IdlePct;
      end
      random_buffer();
      if ($urandom_range(29) == 0) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (chk.errors == 0 && chk.expected_results.size() == 0) begin
      $display("frame_deframer_with_sum_check verification clean");
    end else begin
      $display("frame_deframer_with_sum_check verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fdsc_pkg.sv
hw/rtl/fdsc_res_queue.sv
hw/rtl/frame_deframer_with_sum_check.sv
tb/sv/testbench.sv
